FILE: design/point_segment_distance_top_defines.svh
// Assertion macros used by the point-to-segment distance top level
`ifndef POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PSD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point_segment_distance same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point_segment_distance next-cycle check failed");

`endif

FILE: design/psd_pkg.sv
// Types and constants for the point-to-segment distance pipeline
`timescale 1ns / 1ps
package psd_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = 33;
  localparam int ProdW  = 66;
  localparam int SumW   = 67;
  localparam int RemW   = 68;
  localparam int QuotW  = 33;
  localparam int RootW  = 33;
  localparam int SqRemW = 36;
  localparam int DistW  = 33;
  localparam int Stages = 33;
  localparam int OffW   = ProdW - CoordW;

  typedef enum logic [1:0] {
    CASE_DEGEN  = 2'd0,
    CASE_BEFORE = 2'd1,
    CASE_AFTER  = 2'd2,
    CASE_INSIDE = 2'd3
  } psd_case_t;

  typedef struct packed {
    logic signed [CoordW-1:0] seg_start_x;
    logic signed [CoordW-1:0] seg_start_y;
    logic signed [CoordW-1:0] seg_end_x;
    logic signed [CoordW-1:0] seg_end_y;
    logic signed [CoordW-1:0] query_x;
    logic signed [CoordW-1:0] query_y;
  } psd_in_t;

  typedef struct packed {
    logic [DistW-1:0]         distance;
    logic signed [CoordW-1:0] closest_x;
    logic signed [CoordW-1:0] closest_y;
    logic [1:0]               where_case;
  } psd_out_t;

  typedef struct packed {
    psd_in_t                 pts;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    psd_case_t               kase;
  } psd_carry_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    psd_case_t                kase;
  } psd_pt_t;

  typedef struct packed {
    logic valid;
    logic adv;
  } psd_ctl_t;

endpackage

FILE: design/psd_div_cell.sv
// One restoring-division cell: yields one quotient bit of the projection parameter
`timescale 1ns / 1ps
module psd_div_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  psd_pkg::psd_ctl_t          src_ctl,
  input  logic [psd_pkg::RemW-1:0]   src_rem,
  input  logic [psd_pkg::SumW-1:0]   src_len2,
  input  logic [psd_pkg::QuotW-1:0]  src_q,
  input  psd_pkg::psd_carry_t        src_carry,
  output logic                       dst_valid,
  output logic [psd_pkg::RemW-1:0]   dst_rem,
  output logic [psd_pkg::SumW-1:0]   dst_len2,
  output logic [psd_pkg::QuotW-1:0]  dst_q,
  output psd_pkg::psd_carry_t        dst_carry
);
  import psd_pkg::*;

  logic            ge;
  logic [RemW-1:0] diff;

  assign ge   = src_rem >= {1'b0, src_len2};
  assign diff = ge ? src_rem - {1'b0, src_len2} : src_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ctl.adv) begin
      dst_valid <= src_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ctl.adv) begin
      dst_rem   <= {diff[RemW-2:0], 1'b0};
      dst_len2  <= src_len2;
      dst_q     <= {src_q[QuotW-2:0], ge};
      dst_carry <= src_carry;
    end
  end

endmodule

FILE: design/psd_sqrt_cell.sv
// One digit-by-digit square-root cell: yields one bit of the distance
`timescale 1ns / 1ps
module psd_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  psd_pkg::psd_ctl_t           src_ctl,
  input  logic [psd_pkg::ProdW-1:0]   src_v,
  input  logic [psd_pkg::SqRemW-1:0]  src_rem,
  input  logic [psd_pkg::RootW-1:0]   src_root,
  input  psd_pkg::psd_pt_t            src_pt,
  output logic                        dst_valid,
  output logic [psd_pkg::ProdW-1:0]   dst_v,
  output logic [psd_pkg::SqRemW-1:0]  dst_rem,
  output logic [psd_pkg::RootW-1:0]   dst_root,
  output psd_pkg::psd_pt_t            dst_pt
);
  import psd_pkg::*;

  logic [SqRemW-1:0] rem_sh;
  logic [SqRemW-1:0] trial;
  logic              ge;

  assign rem_sh = {src_rem[SqRemW-3:0], src_v[ProdW-1:ProdW-2]};
  assign trial  = {1'b0, src_root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (src_ctl.adv) begin
      dst_valid <= src_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ctl.adv) begin
      dst_v    <= {src_v[ProdW-3:0], 2'b00};
      dst_rem  <= ge ? rem_sh - trial : rem_sh;
      dst_root <= {src_root[RootW-2:0], ge};
      dst_pt   <= src_pt;
    end
  end

endmodule

FILE: design/point_segment_distance_top.sv
// Top level of the pipelined point-to-segment distance block
//
// Channels: query (segment start, segment end, query point, signed Q16.16)
// and result (distance unsigned Q17.16, nearest point, case code), each a
// valid/ready pair carrying one packed struct per beat.
// Path: an accepted query beat passes through three set-up stages, a row
// of 33 division cells that make the projection parameter one bit each,
// four stages for the nearest point and squared distance, and a row of 33
// square-root cells.
// Throughput: one beat per cycle unless the result side stalls; every cell
// hands its work on whenever the row advances, so 73 queries may be in flight.
// Stall: while a result beat is held and result_ready is low, the whole row
// freezes and query_ready drops; all beats are kept in order.
// Reset: rst, synchronous, clears every stage's valid bit; the block takes
// a query straight after reset.
`timescale 1ns / 1ps
`include "point_segment_distance_top_defines.svh"
module point_segment_distance_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              query_valid,
  output logic              query_ready,
  input  psd_pkg::psd_in_t  query,
  output logic              result_valid,
  input  logic              result_ready,
  output psd_pkg::psd_out_t result
);
  import psd_pkg::*;

  logic adv;
  assign adv         = result_ready || !result_valid;
  assign query_ready = adv;

  // set-up stage 1: differences
  logic                    v1;
  psd_in_t                 p1;
  logic signed [DiffW-1:0] dx1, dy1, wx1, wy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= query_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1  <= query;
      dx1 <= DiffW'(query.seg_end_x) - DiffW'(query.seg_start_x);
      dy1 <= DiffW'(query.seg_end_y) - DiffW'(query.seg_start_y);
      wx1 <= DiffW'(query.query_x) - DiffW'(query.seg_start_x);
      wy1 <= DiffW'(query.query_y) - DiffW'(query.seg_start_y);
    end
  end

  // set-up stage 2: products
  logic                    v2;
  psd_in_t                 p2;
  logic signed [DiffW-1:0] dx2, dy2;
  logic signed [ProdW-1:0] pxx2, pyy2, pwx2, pwy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2   <= p1;
      dx2  <= dx1;
      dy2  <= dy1;
      pxx2 <= dx1 * dx1;
      pyy2 <= dy1 * dy1;
      pwx2 <= wx1 * dx1;
      pwy2 <= wy1 * dy1;
    end
  end

  // set-up stage 3: length squared, dot product, case
  logic                    v3;
  logic [SumW-1:0]         len2_c, len2_3;
  logic signed [SumW-1:0]  dot_c;
  logic [RemW-1:0]         rem3;
  psd_case_t               kase_c;
  psd_carry_t              carry3;

  assign len2_c = {1'b0, pxx2[ProdW-1:0]} + {1'b0, pyy2[ProdW-1:0]};
  assign dot_c  = {pwx2[ProdW-1], pwx2} + {pwy2[ProdW-1], pwy2};

  always_comb begin
    if (len2_c == '0) begin
      kase_c = CASE_DEGEN;
    end else if (dot_c[SumW-1]) begin
      kase_c = CASE_BEFORE;
    end else if ($unsigned(dot_c) > len2_c) begin
      kase_c = CASE_AFTER;
    end else begin
      kase_c = CASE_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len2_3      <= len2_c;
      rem3        <= (kase_c == CASE_INSIDE) ? {1'b0, $unsigned(dot_c)} : '0;
      carry3.pts  <= p2;
      carry3.dx   <= dx2;
      carry3.dy   <= dy2;
      carry3.kase <= kase_c;
    end
  end

  // division row
  logic             div_valid [0:Stages];
  logic [RemW-1:0]  div_rem   [0:Stages];
  logic [SumW-1:0]  div_len2  [0:Stages];
  logic [QuotW-1:0] div_q     [0:Stages];
  psd_carry_t       div_carry [0:Stages];

  assign div_valid[0] = v3;
  assign div_rem[0]   = rem3;
  assign div_len2[0]  = len2_3;
  assign div_q[0]     = '0;
  assign div_carry[0] = carry3;

  for (genvar i = 0; i < Stages; i++) begin : g_div
    psd_ctl_t ctl;
    assign ctl.valid = div_valid[i];
    assign ctl.adv   = adv;
    psd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .src_ctl   (ctl),
      .src_rem   (div_rem[i]),
      .src_len2  (div_len2[i]),
      .src_q     (div_q[i]),
      .src_carry (div_carry[i]),
      .dst_valid (div_valid[i+1]),
      .dst_rem   (div_rem[i+1]),
      .dst_len2  (div_len2[i+1]),
      .dst_q     (div_q[i+1]),
      .dst_carry (div_carry[i+1])
    );
  end

  // stage 4: offsets along the segment
  psd_carry_t       c_last;
  logic [DiffW-1:0] adx, ady;
  logic             v4;
  psd_carry_t       carry4;
  logic [ProdW-1:0] mx4, my4;

  assign c_last = div_carry[Stages];
  assign adx    = c_last.dx[DiffW-1] ? DiffW'(-c_last.dx) : $unsigned(c_last.dx);
  assign ady    = c_last.dy[DiffW-1] ? DiffW'(-c_last.dy) : $unsigned(c_last.dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= div_valid[Stages];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      carry4 <= c_last;
      mx4    <= adx * div_q[Stages];
      my4    <= ady * div_q[Stages];
    end
  end

  // stage 5: nearest point and its offset from the query
  logic [OffW-1:0]          ofx, ofy;
  logic [OffW-1:0]          sxe, sye;
  logic signed [CoordW-1:0] cx_c, cy_c;
  logic                     v5;
  psd_pt_t                  pt5;
  logic signed [DiffW-1:0]  ex5, ey5;

  assign ofx = mx4[ProdW-1:CoordW];
  assign ofy = my4[ProdW-1:CoordW];
  assign sxe = OffW'(carry4.pts.seg_start_x);
  assign sye = OffW'(carry4.pts.seg_start_y);

  always_comb begin
    case (carry4.kase)
      CASE_DEGEN, CASE_BEFORE: begin
        cx_c = carry4.pts.seg_start_x;
        cy_c = carry4.pts.seg_start_y;
      end
      CASE_AFTER: begin
        cx_c = carry4.pts.seg_end_x;
        cy_c = carry4.pts.seg_end_y;
      end
      default: begin
        cx_c = carry4.dx[DiffW-1] ? $signed(CoordW'(sxe - ofx)) : $signed(CoordW'(sxe + ofx));
        cy_c = carry4.dy[DiffW-1] ? $signed(CoordW'(sye - ofy)) : $signed(CoordW'(sye + ofy));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt5.cx   <= cx_c;
      pt5.cy   <= cy_c;
      pt5.kase <= carry4.kase;
      ex5      <= DiffW'(carry4.pts.query_x) - DiffW'(cx_c);
      ey5      <= DiffW'(carry4.pts.query_y) - DiffW'(cy_c);
    end
  end

  // stage 6: squares
  logic                    v6;
  psd_pt_t                 pt6;
  logic signed [ProdW-1:0] sqx6, sqy6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt6  <= pt5;
      sqx6 <= ex5 * ex5;
      sqy6 <= ey5 * ey5;
    end
  end

  // stage 7: squared distance
  logic             v7;
  psd_pt_t          pt7;
  logic [ProdW-1:0] dsq7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt7  <= pt6;
      dsq7 <= $unsigned(sqx6) + $unsigned(sqy6);
    end
  end

  // square-root row
  logic              sq_valid [0:Stages];
  logic [ProdW-1:0]  sq_v     [0:Stages];
  logic [SqRemW-1:0] sq_rem   [0:Stages];
  logic [RootW-1:0]  sq_root  [0:Stages];
  psd_pt_t           sq_pt    [0:Stages];

  assign sq_valid[0] = v7;
  assign sq_v[0]     = dsq7;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_pt[0]    = pt7;

  for (genvar j = 0; j < Stages; j++) begin : g_sqrt
    psd_ctl_t ctl;
    assign ctl.valid = sq_valid[j];
    assign ctl.adv   = adv;
    psd_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .src_ctl   (ctl),
      .src_v     (sq_v[j]),
      .src_rem   (sq_rem[j]),
      .src_root  (sq_root[j]),
      .src_pt    (sq_pt[j]),
      .dst_valid (sq_valid[j+1]),
      .dst_v     (sq_v[j+1]),
      .dst_rem   (sq_rem[j+1]),
      .dst_root  (sq_root[j+1]),
      .dst_pt    (sq_pt[j+1])
    );
  end

  assign result_valid      = sq_valid[Stages];
  assign result.distance   = sq_root[Stages];
  assign result.closest_x  = sq_pt[Stages].cx;
  assign result.closest_y  = sq_pt[Stages].cy;
  assign result.where_case = sq_pt[Stages].kase;

  `PSD_ASSERT_NEXT(a_stall_hold, clk, rst, result_valid && !result_ready,
                   result_valid && $stable(result))
  `PSD_ASSERT_SAME(a_quot_range, clk, rst,
                   div_valid[Stages] && (div_carry[Stages].kase == CASE_INSIDE),
                   div_q[Stages] <= {1'b1, {(QuotW-1){1'b0}}})
  `PSD_ASSERT_SAME(a_div_rem, clk, rst,
                   div_valid[Stages] && (div_carry[Stages].kase == CASE_INSIDE),
                   div_rem[Stages] < {div_len2[Stages], 1'b0})
  `PSD_ASSERT_SAME(a_sqrt_rem, clk, rst, result_valid,
                   sq_rem[Stages][SqRemW-1:SqRemW-2] == 2'b00)
  `PSD_ASSERT_NEXT(a_row_drain, clk, rst, adv && sq_valid[Stages-1], result_valid)

endmodule
